### src/i2cm_seq_pkg.sv
package i2cm_seq_pkg;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_ADDR  = 3'd2,
        ACT_DATA  = 3'd3,
        ACT_ACK   = 3'd4,
        ACT_NACK  = 3'd5,
        ACT_STOP  = 3'd6
    } action_t;

    typedef enum logic [0:0] {
        CMD_BEGIN  = 1'b0,
        CMD_STATUS = 1'b1
    } command_t;

    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
    localparam logic [7:0] ST_MT_DAT_ACK = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
    localparam logic [7:0] ST_MR_DAT_ACK = 8'h50;
    localparam logic [7:0] ST_MR_DAT_NAK = 8'h58;
    localparam logic [7:0] ST_NO_INFO    = 8'hF8;

    function automatic logic ends_well(input logic [7:0] code);
        ends_well = (code == ST_MT_SLA_ACK) || (code == ST_MT_DAT_ACK) ||
                    (code == ST_MR_DAT_NAK) || (code == ST_NO_INFO);
    endfunction

endpackage

### src/i2c_master_transaction_sequencer.sv
// I2C master transfer sequencer. A begin transfer (s_command 0) latches the
// address byte, byte count and stop request and answers START; every status
// transfer from the byte engine (s_command 1) answers the next engine action,
// carries a received byte on the status that follows an ACK or NACK, and
// flags completion with success or error. One result per input transfer.
// An item is accepted every cycle: the step is a single decode and a 16-bit
// compare/increment on the held transfer state, landing in one output
// register, and s_ready drops only while that output register holds a
// result that m_ready has not taken.
module i2c_master_transaction_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_slave_address,
    input  logic [15:0] s_byte_count,
    input  logic        s_stop_wanted,
    input  logic [7:0]  s_bus_status,
    input  logic [7:0]  s_received_data,
    input  logic [7:0]  s_next_tx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output i2cm_seq_pkg::action_t m_action,
    output logic [7:0]  m_tx_byte,
    output logic [15:0] m_byte_index,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic        m_done_res,
    output logic        m_failed
);
    import i2cm_seq_pkg::*;

    logic        active_reg, active_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] total_bytes_reg, total_bytes_next;
    logic        stop_flag_reg, stop_flag_next;
    logic [7:0]  address_byte_reg, address_byte_next;
    logic        receive_pending_reg, receive_pending_next;

    logic        m_valid_reg;
    action_t     action_reg, action_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic        rx_valid_reg, rx_valid_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;
    logic        done_reg, done_next;
    logic        failed_reg, failed_next;

    logic        accept;
    logic        finish;
    logic        more_left;
    logic        not_last;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign more_left = position_reg < total_bytes_reg;
    assign not_last  = position_reg < (total_bytes_reg - 16'd1);

    always_comb begin
        active_next          = active_reg;
        position_next        = position_reg;
        total_bytes_next     = total_bytes_reg;
        stop_flag_next       = stop_flag_reg;
        address_byte_next    = address_byte_reg;
        receive_pending_next = receive_pending_reg;
        action_next          = ACT_NONE;
        tx_byte_next         = 8'd0;
        byte_index_next      = 16'd0;
        rx_valid_next        = 1'b0;
        rx_byte_next         = 8'd0;
        done_next            = 1'b0;
        failed_next          = 1'b0;
        finish               = 1'b0;

        if (s_command == CMD_BEGIN) begin
            active_next          = 1'b1;
            position_next        = 16'd0;
            total_bytes_next     = s_byte_count;
            stop_flag_next       = s_stop_wanted;
            address_byte_next    = s_slave_address;
            receive_pending_next = 1'b0;
            action_next          = ACT_START;
        end else if (active_reg) begin
            if (receive_pending_reg) begin
                rx_valid_next        = 1'b1;
                rx_byte_next         = s_received_data;
                byte_index_next      = position_reg - 16'd1;
                receive_pending_next = 1'b0;
            end
            unique case (s_bus_status)
                ST_START, ST_REP_START: begin
                    action_next  = ACT_ADDR;
                    tx_byte_next = address_byte_reg;
                end
                ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
                    if (more_left) begin
                        action_next     = ACT_DATA;
                        tx_byte_next    = s_next_tx_byte;
                        byte_index_next = position_reg;
                        position_next   = position_reg + 16'd1;
                    end else begin
                        finish = 1'b1;
                    end
                end
                ST_MR_SLA_ACK, ST_MR_DAT_ACK: begin
                    if (more_left) begin
                        action_next = not_last ? ACT_ACK : ACT_NACK;
                        if (!receive_pending_reg) begin
                            byte_index_next = position_reg;
                        end
                        receive_pending_next = 1'b1;
                        position_next        = position_reg + 16'd1;
                    end else begin
                        finish = 1'b1;
                    end
                end
                ST_MR_DAT_NAK, ST_NO_INFO: begin
                    finish = 1'b1;
                end
                default: begin
                    stop_flag_next = 1'b1;
                    finish         = 1'b1;
                end
            endcase
            if (finish) begin
                active_next          = 1'b0;
                receive_pending_next = 1'b0;
                action_next          = stop_flag_next ? ACT_STOP : ACT_NONE;
                done_next            = 1'b1;
                failed_next          = !ends_well(s_bus_status);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg          <= 1'b0;
            position_reg        <= 16'd0;
            total_bytes_reg     <= 16'd0;
            stop_flag_reg       <= 1'b0;
            address_byte_reg    <= 8'd0;
            receive_pending_reg <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (accept) begin
                active_reg          <= active_next;
                position_reg        <= position_next;
                total_bytes_reg     <= total_bytes_next;
                stop_flag_reg       <= stop_flag_next;
                address_byte_reg    <= address_byte_next;
                receive_pending_reg <= receive_pending_next;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg     <= action_next;
            tx_byte_reg    <= tx_byte_next;
            byte_index_reg <= byte_index_next;
            rx_valid_reg   <= rx_valid_next;
            rx_byte_reg    <= rx_byte_next;
            done_reg       <= done_next;
            failed_reg     <= failed_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = action_reg;
    assign m_tx_byte    = tx_byte_reg;
    assign m_byte_index = byte_index_reg;
    assign m_rx_valid   = rx_valid_reg;
    assign m_rx_byte    = rx_byte_reg;
    assign m_done_res   = done_reg;
    assign m_failed     = failed_reg;

    a_done_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> (action_reg == ACT_STOP) || (action_reg == ACT_NONE))
        else $error("finish with an action other than stop or none");

    a_fail_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && failed_reg |-> done_reg)
        else $error("error flag without finish");

    a_begin_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_command == CMD_BEGIN) |=> active_reg && m_valid_reg &&
            (action_reg == ACT_START) && !receive_pending_reg)
        else $error("begin transfer did not start");

    a_done_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_command == CMD_STATUS) |=> !(done_reg && (active_reg ||
            receive_pending_reg)))
        else $error("state still busy after finish");

    a_pending_active: assert property (@(posedge aclk) disable iff (!aresetn)
        receive_pending_reg |-> active_reg)
        else $error("receive pending while idle");

endmodule

### verif/tb.sv
module tb;
    import i2cm_seq_pkg::*;

    localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
    localparam logic [7:0] ST_MT_SLA_NAK = 8'h20;
    localparam logic [7:0] ST_MT_DAT_NAK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_MR_SLA_NAK = 8'h48;

    typedef struct {
        command_t    cmd;
        logic [7:0]  sla;
        logic [15:0] count;
        logic        stop;
        logic [7:0]  status;
        logic [7:0]  rxd;
        logic [7:0]  txb;
        logic        drain;
    } bus_item_t;

    typedef struct {
        action_t     act;
        logic [7:0]  tx;
        logic [15:0] idx;
        logic        rxv;
        logic [7:0]  rxb;
        logic        done;
        logic        fail;
    } engine_action_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [7:0]  s_slave_address = 8'h00;
    logic [15:0] s_byte_count = 16'h0000;
    logic        s_stop_wanted = 1'b0;
    logic [7:0]  s_bus_status = 8'h00;
    logic [7:0]  s_received_data = 8'h00;
    logic [7:0]  s_next_tx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    action_t     m_action;
    logic [7:0]  m_tx_byte;
    logic [15:0] m_byte_index;
    logic        m_rx_valid;
    logic [7:0]  m_rx_byte;
    logic        m_done_res;
    logic        m_failed;

    bus_item_t      bus_item_q[$];
    engine_action_t engine_action_q[$];
    int             n_items = 0;
    int             n_errors = 0;
    int             results_owed = 0;
    int             drv_cyc = 0;
    int             rcv_cyc = 0;

    logic        xfer_active = 1'b0;
    logic [15:0] xfer_pos = 16'h0000;
    logic [15:0] xfer_total = 16'h0000;
    logic        xfer_stop = 1'b0;
    logic [7:0]  xfer_addr = 8'h00;
    logic        rx_owed = 1'b0;

    i2c_master_transaction_sequencer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_slave_address (s_slave_address),
        .s_byte_count    (s_byte_count),
        .s_stop_wanted   (s_stop_wanted),
        .s_bus_status    (s_bus_status),
        .s_received_data (s_received_data),
        .s_next_tx_byte  (s_next_tx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_tx_byte       (m_tx_byte),
        .m_byte_index    (m_byte_index),
        .m_rx_valid      (m_rx_valid),
        .m_rx_byte       (m_rx_byte),
        .m_done_res      (m_done_res),
        .m_failed        (m_failed)
    );

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic sequence_step(input bus_item_t it, output engine_action_t r);
        logic finish;
        logic [15:0] last_pos;
        finish = 1'b0;
        last_pos = xfer_total - 16'd1;
        r = '{ACT_NONE, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0};
        if (it.cmd == CMD_BEGIN) begin
            xfer_active = 1'b1;
            xfer_pos = 16'h0000;
            xfer_total = it.count;
            xfer_stop = it.stop;
            xfer_addr = it.sla;
            rx_owed = 1'b0;
            r.act = ACT_START;
        end else if (xfer_active) begin
            if (rx_owed) begin
                r.rxv = 1'b1;
                r.rxb = it.rxd;
                r.idx = xfer_pos - 16'd1;
                rx_owed = 1'b0;
            end
            case (it.status)
                ST_START, ST_REP_START: begin
                    r.act = ACT_ADDR;
                    r.tx = xfer_addr;
                end
                ST_MT_SLA_ACK, ST_MT_DAT_ACK: begin
                    if (xfer_pos < xfer_total) begin
                        r.act = ACT_DATA;
                        r.tx = it.txb;
                        r.idx = xfer_pos;
                        xfer_pos = xfer_pos + 16'd1;
                    end else begin
                        finish = 1'b1;
                    end
                end
                ST_MR_SLA_ACK, ST_MR_DAT_ACK: begin
                    if (xfer_pos < xfer_total) begin
                        r.act = (xfer_pos < last_pos) ? ACT_ACK : ACT_NACK;
                        if (!r.rxv) begin
                            r.idx = xfer_pos;
                        end
                        rx_owed = 1'b1;
                        xfer_pos = xfer_pos + 16'd1;
                    end else begin
                        finish = 1'b1;
                    end
                end
                ST_MR_DAT_NAK, ST_NO_INFO: begin
                    finish = 1'b1;
                end
                default: begin
                    xfer_stop = 1'b1;
                    finish = 1'b1;
                end
            endcase
            if (finish) begin
                xfer_active = 1'b0;
                rx_owed = 1'b0;
                r.act = xfer_stop ? ACT_STOP : ACT_NONE;
                r.done = 1'b1;
                r.fail = !(it.status == ST_MT_SLA_ACK || it.status == ST_MT_DAT_ACK ||
                           it.status == ST_MR_DAT_NAK || it.status == ST_NO_INFO);
            end
        end
    endtask

    task automatic queue_begin(input logic [7:0] sla, input logic [15:0] count,
                               input logic stop, input logic drain);
        bus_item_t it;
        it.cmd = CMD_BEGIN;
        it.sla = sla;
        it.count = count;
        it.stop = stop;
        it.status = 8'($urandom);
        it.rxd = 8'($urandom);
        it.txb = 8'($urandom);
        it.drain = drain;
        bus_item_q.push_back(it);
        n_items++;
    endtask

    task automatic queue_status(input logic [7:0] status);
        bus_item_t it;
        it.cmd = CMD_STATUS;
        it.sla = 8'($urandom);
        it.count = 16'($urandom);
        it.stop = 1'($urandom);
        it.status = status;
        it.rxd = 8'($urandom);
        it.txb = 8'($urandom);
        it.drain = 1'b0;
        bus_item_q.push_back(it);
        n_items++;
    endtask

    function automatic logic [7:0] any_status();
        logic [7:0] code;
        case ($urandom_range(0, 15))
            0: code = ST_START;
            1: code = ST_REP_START;
            2: code = ST_MT_SLA_ACK;
            3: code = ST_MT_DAT_ACK;
            4: code = ST_MR_SLA_ACK;
            5: code = ST_MR_DAT_ACK;
            6: code = ST_MR_DAT_NAK;
            7: code = ST_NO_INFO;
            8: code = ST_BUS_ERROR;
            9: code = ST_MT_SLA_NAK;
            10: code = ST_MT_DAT_NAK;
            11: code = ST_ARB_LOST;
            12: code = ST_MR_SLA_NAK;
            default: code = 8'($urandom);
        endcase
        return code;
    endfunction

    task automatic queue_transfer(input logic drain);
        logic        rd;
        logic [15:0] n;
        int          cut;
        int          len;
        logic [7:0]  code;
        rd = 1'($urandom);
        case ($urandom_range(0, 19))
            0: n = 16'hFFFF;
            1: n = 16'($urandom);
            default: n = 16'($urandom_range(0, 6));
        endcase
        cut = -1;
        if (n > 16'd6 || $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, 7);
        end
        queue_begin({7'($urandom), rd}, n, 1'($urandom), drain);
        len = (rd && n == 16'd0) ? 2 : int'(n) + 2;
        for (int k = 0; k < len; k++) begin
            if (k == cut) begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_begin(8'($urandom), 16'($urandom_range(0, 6)), 1'($urandom),
                                1'b0);
                end else begin
                    queue_status(any_status());
                end
                return;
            end
            if (k == 0) begin
                code = ($urandom_range(0, 4) == 0) ? ST_REP_START : ST_START;
            end else if (!rd) begin
                code = (k == 1) ? ST_MT_SLA_ACK : ST_MT_DAT_ACK;
            end else if (k == 1) begin
                code = ST_MR_SLA_ACK;
            end else begin
                code = (k == len - 1) ? ST_MR_DAT_NAK : ST_MR_DAT_ACK;
            end
            queue_status(code);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    always @(posedge aclk) begin : drive
        bus_item_t nxt;
        logic      go;
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_cyc <= 0;
        end else begin
            drv_cyc <= drv_cyc + 1;
            if (!s_valid || s_ready) begin
                go = 1'b0;
                if (bus_item_q.size() != 0) begin
                    go = (drv_cyc >= 800 && drv_cyc < 1100) ||
                         ($urandom_range(0, 99) >= 15);
                    // hold until every owed result is out
                    if (bus_item_q[0].drain &&
                        (results_owed != 0 || m_valid || (s_valid && s_ready))) begin
                        go = 1'b0;
                    end
                end
                if (go) begin
                    nxt = bus_item_q.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.cmd;
                    s_slave_address <= nxt.sla;
                    s_byte_count <= nxt.count;
                    s_stop_wanted <= nxt.stop;
                    s_bus_status <= nxt.status;
                    s_received_data <= nxt.rxd;
                    s_next_tx_byte <= nxt.txb;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : sink
        if (!aresetn) begin
            m_ready <= 1'b0;
            rcv_cyc <= 0;
        end else begin
            rcv_cyc <= rcv_cyc + 1;
            if (rcv_cyc >= 300 && rcv_cyc < 500) begin
                m_ready <= 1'b0;
            end else if (rcv_cyc >= 800 && rcv_cyc < 1100) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

    always @(posedge aclk) begin : watch
        bus_item_t      seen;
        engine_action_t want;
        engine_action_t pred;
        int             took;
        int             pushed;
        if (aresetn) begin
            took = 0;
            pushed = 0;
            if (m_valid && m_ready) begin
                if (engine_action_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = engine_action_q.pop_front();
                    took = 1;
                    check_field("action", 16'(m_action), 16'(want.act));
                    check_field("tx_byte", 16'(m_tx_byte), 16'(want.tx));
                    check_field("byte_index", m_byte_index, want.idx);
                    check_field("rx_valid", 16'(m_rx_valid), 16'(want.rxv));
                    check_field("rx_byte", 16'(m_rx_byte), 16'(want.rxb));
                    check_field("done_res", 16'(m_done_res), 16'(want.done));
                    check_field("failed", 16'(m_failed), 16'(want.fail));
                end
            end
            if (s_valid && s_ready) begin
                seen.cmd = command_t'(s_command);
                seen.sla = s_slave_address;
                seen.count = s_byte_count;
                seen.stop = s_stop_wanted;
                seen.status = s_bus_status;
                seen.rxd = s_received_data;
                seen.txb = s_next_tx_byte;
                seen.drain = 1'b0;
                sequence_step(seen, pred);
                engine_action_q.push_back(pred);
                pushed = 1;
            end
            results_owed <= results_owed + pushed - took;
        end
    end

    initial begin : run
        int transfers;
        int guard;
        transfers = 0;

        queue_status(ST_START);
        queue_begin(8'hA0, 16'd1, 1'b1, 1'b0);
        queue_status(ST_START);
        queue_status(ST_MT_SLA_ACK);
        queue_status(ST_MT_DAT_ACK);
        queue_begin(8'hFF, 16'd2, 1'b0, 1'b0);
        queue_status(ST_REP_START);
        queue_status(ST_MR_SLA_ACK);
        queue_status(ST_MR_DAT_ACK);
        queue_status(ST_MR_DAT_NAK);
        queue_begin(8'h00, 16'd0, 1'b0, 1'b0);
        queue_status(ST_START);
        queue_status(ST_MT_SLA_ACK);
        queue_begin(8'h01, 16'hFFFF, 1'b0, 1'b0);
        queue_status(ST_MR_SLA_NAK);
        queue_begin(8'h81, 16'd0, 1'b0, 1'b0);
        queue_status(ST_MR_SLA_ACK);
        queue_begin(8'h42, 16'd3, 1'b1, 1'b0);
        queue_status(ST_START);
        queue_begin(8'h43, 16'd1, 1'b0, 1'b0);
        queue_status(ST_NO_INFO);
        queue_begin(8'h7E, 16'd4, 1'b0, 1'b0);
        queue_status(ST_BUS_ERROR);
        queue_begin(8'h7F, 16'd4, 1'b0, 1'b0);
        queue_status(ST_ARB_LOST);

        while (n_items < 1025) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_transfer(transfers % 40 == 39);
                transfers++;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        queue_begin(8'($urandom), 16'($urandom), 1'($urandom), 1'b0);
                    end else begin
                        queue_status(any_status());
                    end
                end
            end
        end

        wait (aresetn === 1'b1);
        do @(negedge aclk); while (bus_item_q.size() != 0 || s_valid);
        guard = 0;
        while ((engine_action_q.size() != 0 || m_valid) && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (10) @(negedge aclk);
        if (engine_action_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      engine_action_q.size()));
        end
        if (n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
